@@ design/mtlq_pkg.sv @@
`default_nettype none
package mtlq_pkg;

	localparam int DEPTH  = 64;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int OCC_W  = 7;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
	localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
	localparam logic [1:0] STAT_EMPTY     = 2'd3;

	localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

	typedef struct packed {
		logic [1:0]               cmd;
		logic signed [DATA_W-1:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] removed_value;
		logic signed [DATA_W-1:0] min_value;
		logic                     min_valid;
		logic [OCC_W-1:0]         occupancy;
	} out_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_POP  = 3'b010,
		ST_SCAN = 3'b100
	} state_t;

endpackage
`default_nettype wire

@@ design/mtlq_ram.sv @@
`default_nettype none
module mtlq_ram #(
	parameter int DATA_W = 32,
	parameter int ADDR_W = 6,
	parameter int WORDS  = 64
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

@@ design/min_tracking_linear_queue.sv @@
// Linear queue of signed 32-bit values with a running minimum.
// Input channel in_valid/in_ready carries one item: cmd (insert, delete,
// query) and value. Output channel out_valid/out_ready returns one result
// per item: status, removed value, minimum, min_valid and occupancy.
// Insert, query and any failing operation: the result is formed in the
// accepting cycle and registered. Delete: one entry-store read of the head
// entry. When the popped entry equals the minimum and entries remain, the
// remaining entries are rescanned one per cycle through the single read
// port of the entry store. One item is in work at a time.
// Slots are never reused; after DEPTH inserts every insert overflows.
// Results go to an output register backed by one holding register, so a
// new item is taken while a finished result waits; when both are full,
// in_ready drops until the receiver takes a result.
// Reset clears head, tail, minimum and all valid flags; the entry store
// needs no clearing since only written slots are ever read.
`default_nettype none
module min_tracking_linear_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output      logic           in_ready,
	input  wire mtlq_pkg::in_t  in_data,
	output      logic           out_valid,
	input  wire logic           out_ready,
	output      mtlq_pkg::out_t out_data
);
	import mtlq_pkg::*;

	state_t                   state_q, state_d;
	logic [CNT_W-1:0]         head_q, head_d;
	logic [CNT_W-1:0]         tail_q, tail_d;
	logic [CNT_W-1:0]         scan_q, scan_d;
	logic signed [DATA_W-1:0] min_q, min_d;
	logic signed [DATA_W-1:0] acc_q, acc_d;
	logic signed [DATA_W-1:0] removed_q, removed_d;
	out_t                     out_q, pend_q, res;
	logic                     out_valid_q, pend_valid_q;
	logic                     res_load, out_free, in_fire, empty;
	logic                     we;
	logic [ADDR_W-1:0]        waddr, raddr;
	logic [DATA_W-1:0]        rdata_raw;
	logic signed [DATA_W-1:0] rdata, cand;
	logic [CNT_W-1:0]         head_inc, scan_inc;

	function automatic out_t make_res(
		input logic [1:0]               status,
		input logic signed [DATA_W-1:0] removed,
		input logic [CNT_W-1:0]         head,
		input logic [CNT_W-1:0]         tail,
		input logic signed [DATA_W-1:0] mn
	);
		out_t r;
		logic nonempty;
		nonempty        = head != tail;
		r.status        = status;
		r.removed_value = removed;
		r.min_value     = nonempty ? mn : '0;
		r.min_valid     = nonempty;
		r.occupancy     = OCC_W'(tail - head);
		return r;
	endfunction

	mtlq_ram #(
		.DATA_W(DATA_W),
		.ADDR_W(ADDR_W),
		.WORDS (DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(in_data.value),
		.raddr(raddr),
		.rdata(rdata_raw)
	);

	assign rdata    = rdata_raw;
	assign in_ready = (state_q == ST_IDLE) && !pend_valid_q;
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign empty    = head_q == tail_q;
	assign head_inc = head_q + CNT_W'(1);
	assign scan_inc = scan_q + CNT_W'(1);
	assign cand     = (rdata < acc_q) ? rdata : acc_q;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		tail_d    = tail_q;
		scan_d    = scan_q;
		min_d     = min_q;
		acc_d     = acc_q;
		removed_d = removed_q;
		we        = 1'b0;
		waddr     = tail_q[ADDR_W-1:0];
		raddr     = head_q[ADDR_W-1:0];
		res_load  = 1'b0;
		res       = make_res(STAT_OK, '0, head_q, tail_q, min_q);
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					unique case (in_data.cmd)
						CMD_INSERT: begin
							res_load = 1'b1;
							if (tail_q >= CNT_W'(DEPTH)) begin
								res = make_res(STAT_OVERFLOW, '0, head_q, tail_q, min_q);
							end else begin
								we     = 1'b1;
								tail_d = tail_q + CNT_W'(1);
								if (empty || (in_data.value < min_q)) begin
									min_d = in_data.value;
								end
								res = make_res(STAT_OK, '0, head_q, tail_d, min_d);
							end
						end
						CMD_DELETE: begin
							if (empty) begin
								res_load = 1'b1;
								res = make_res(STAT_UNDERFLOW, '0, head_q, tail_q, min_q);
							end else begin
								state_d = ST_POP;
							end
						end
						default: begin
							res_load = 1'b1;
							res = make_res(empty ? STAT_EMPTY : STAT_OK, '0,
								head_q, tail_q, min_q);
						end
					endcase
				end
			end
			ST_POP: begin
				removed_d = rdata;
				head_d    = head_inc;
				if ((rdata == min_q) && (head_inc < tail_q)) begin
					raddr   = head_inc[ADDR_W-1:0];
					scan_d  = head_inc;
					acc_d   = VAL_MAX;
					state_d = ST_SCAN;
				end else begin
					res_load = 1'b1;
					res      = make_res(STAT_OK, rdata, head_inc, tail_q, min_q);
					state_d  = ST_IDLE;
				end
			end
			ST_SCAN: begin
				acc_d = cand;
				if (scan_inc == tail_q) begin
					min_d    = cand;
					res_load = 1'b1;
					res      = make_res(STAT_OK, removed_q, head_q, tail_q, cand);
					state_d  = ST_IDLE;
				end else begin
					raddr  = scan_inc[ADDR_W-1:0];
					scan_d = scan_inc;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			min_q        <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			min_q   <= min_d;
			if (pend_valid_q && out_free) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (res_load) begin
				if (out_free) begin
					out_valid_q <= 1'b1;
				end else begin
					pend_valid_q <= 1'b1;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q    <= scan_d;
		acc_q     <= acc_d;
		removed_q <= removed_d;
		if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end else if (res_load) begin
			if (out_free) begin
				out_q <= res;
			end else begin
				pend_q <= res;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
module tb;
	import mtlq_pkg::*;

	localparam logic [1:0]               CMD_SPARE  = 2'd3;
	localparam logic signed [DATA_W-1:0] VAL_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
	localparam int                       RAND_ITEMS = 1680;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	min_tracking_linear_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	typedef struct {
		in_t  op;
		bit   typed;
		out_t want;
	} plan_row_t;

	// mirror of the queue contents
	logic signed [DATA_W-1:0] q_store [DEPTH];
	int unsigned              q_head;
	int unsigned              q_tail;
	logic signed [DATA_W-1:0] q_min;

	out_t        outcome_q [$];
	plan_row_t   plan_rows [$];
	int unsigned mismatches;
	bit          tx_calm;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		#15_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic out_t queue_op_outcome(input in_t it);
		out_t                     r;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] popped;
		int unsigned              k;
		r      = '0;
		v      = it.value;
		popped = '0;
		case (it.cmd)
			CMD_INSERT: begin
				if (q_tail >= DEPTH) begin
					r.status = STAT_OVERFLOW;
				end else begin
					if (q_head == q_tail)
						q_min = v;
					q_store[q_tail[ADDR_W-1:0]] = v;
					q_tail++;
					if (v < q_min)
						q_min = v;
				end
			end
			CMD_DELETE: begin
				if (q_head >= q_tail) begin
					r.status = STAT_UNDERFLOW;
				end else begin
					popped = q_store[q_head[ADDR_W-1:0]];
					q_head++;
					// popped the minimum: rescan what is left
					if (popped == q_min && q_head < q_tail) begin
						q_min = q_store[q_head[ADDR_W-1:0]];
						for (k = q_head + 1; k < q_tail; k++)
							if (q_store[k[ADDR_W-1:0]] < q_min)
								q_min = q_store[k[ADDR_W-1:0]];
					end
				end
			end
			default: begin
				if (q_head >= q_tail)
					r.status = STAT_EMPTY;
			end
		endcase
		r.removed_value = popped;
		r.min_valid     = q_head < q_tail;
		r.min_value     = r.min_valid ? q_min : '0;
		r.occupancy     = OCC_W'(q_tail - q_head);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35)
			return $signed($urandom_range(0, 8)) - 4;
		else if (r < 45) begin
			case ($urandom_range(0, 3))
				0:       return VAL_MAX;
				1:       return VAL_MIN;
				2:       return '0;
				default: return -1;
			endcase
		end
		return $urandom;
	endfunction

	function automatic void plan_op(input logic [1:0] c, input logic signed [DATA_W-1:0] v);
		plan_row_t r;
		r.op.cmd   = c;
		r.op.value = v;
		r.typed    = 1'b0;
		r.want     = '0;
		plan_rows.push_back(r);
	endfunction

	function automatic void plan_chk(input logic [1:0] c, input logic signed [DATA_W-1:0] v,
			input logic [1:0] st, input logic signed [DATA_W-1:0] rm,
			input logic signed [DATA_W-1:0] mn, input logic mv, input logic [OCC_W-1:0] occ);
		plan_row_t r;
		r.op.cmd             = c;
		r.op.value           = v;
		r.typed              = 1'b1;
		r.want.status        = st;
		r.want.removed_value = rm;
		r.want.min_value     = mn;
		r.want.min_valid     = mv;
		r.want.occupancy     = occ;
		plan_rows.push_back(r);
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic send_item(input in_t it, input bit typed, input out_t want);
		int   gap;
		out_t predicted;
		gap = tx_calm ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		do @(posedge clk); while (!in_ready);
		predicted = queue_op_outcome(it);
		outcome_q.push_back(typed ? want : predicted);
	endtask

	// result side: random stalls, field checks
	initial begin
		out_t got;
		out_t want;
		int   rx_hold;
		int   rx_cycles;
		bit   rx_calm;
		rx_hold   = 0;
		rx_cycles = 0;
		rx_calm   = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got = out_data;
				if (outcome_q.size() == 0) begin
					report_mismatch("result with nothing pending");
				end else begin
					want = outcome_q.pop_front();
					if (got.status !== want.status)
						report_mismatch($sformatf("status got %0d want %0d",
							got.status, want.status));
					if (got.removed_value !== want.removed_value)
						report_mismatch($sformatf("removed_value got %0d want %0d",
							got.removed_value, want.removed_value));
					if (got.min_value !== want.min_value)
						report_mismatch($sformatf("min_value got %0d want %0d",
							got.min_value, want.min_value));
					if (got.min_valid !== want.min_valid)
						report_mismatch($sformatf("min_valid got %0d want %0d",
							got.min_valid, want.min_valid));
					if (got.occupancy !== want.occupancy)
						report_mismatch($sformatf("occupancy got %0d want %0d",
							got.occupancy, want.occupancy));
				end
			end
			rx_cycles++;
			if (rx_cycles % 300 == 0)
				rx_calm = ($urandom_range(0, 3) == 0);
			if (rx_hold > 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!rx_calm && $urandom_range(0, 3) == 0)
					rx_hold = pick_gap();
			end
		end
	end

	initial begin
		in_t         op;
		int          r;
		int unsigned n;
		arst_n     = 1'b0;
		in_valid   <= 1'b0;
		in_data    <= '0;
		q_head     = 0;
		q_tail     = 0;
		q_min      = '0;
		mismatches = 0;
		tx_calm    = 1'b0;

		plan_chk(CMD_QUERY,  '0,            STAT_EMPTY,     '0, '0, 1'b0, 0);
		plan_chk(CMD_DELETE, '0,            STAT_UNDERFLOW, '0, '0, 1'b0, 0);
		plan_chk(CMD_SPARE,  32'h5555_5555, STAT_EMPTY,     '0, '0, 1'b0, 0);
		plan_chk(CMD_INSERT, VAL_MAX,       STAT_OK, '0, VAL_MAX, 1'b1, 1);
		plan_chk(CMD_INSERT, VAL_MIN,       STAT_OK, '0, VAL_MIN, 1'b1, 2);
		plan_op(CMD_INSERT, '0);
		plan_op(CMD_INSERT, -1);
		plan_op(CMD_QUERY, 32'hAAAA_AAAA);
		plan_chk(CMD_DELETE, '0, STAT_OK, VAL_MAX, VAL_MIN, 1'b1, 3);
		plan_op(CMD_DELETE, '0);
		plan_op(CMD_DELETE, '0);
		// queue empties on a minimum pop: no rescan
		plan_chk(CMD_DELETE, '0, STAT_OK, -1, '0, 1'b0, 0);
		plan_chk(CMD_QUERY,  '0, STAT_EMPTY,     '0, '0, 1'b0, 0);
		plan_chk(CMD_DELETE, '0, STAT_UNDERFLOW, '0, '0, 1'b0, 0);
		// minimum restarts on insert into an emptied queue
		plan_chk(CMD_INSERT, 100, STAT_OK, '0, 100, 1'b1, 1);
		plan_op(CMD_INSERT, 100);
		plan_op(CMD_INSERT, 300);
		plan_op(CMD_DELETE, '0);
		plan_op(CMD_INSERT, VAL_MIN);
		plan_op(CMD_INSERT, VAL_MAX);
		plan_op(CMD_DELETE, '0);
		plan_op(CMD_DELETE, '0);
		plan_op(CMD_SPARE, '0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_rows[i])
			send_item(plan_rows[i].op, plan_rows[i].typed, plan_rows[i].want);

		for (n = 0; n < RAND_ITEMS; n++) begin
			if (n % 100 == 0)
				tx_calm = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (q_tail < DEPTH)
				op.cmd = (r < 65) ? CMD_INSERT : (r < 90) ? CMD_DELETE :
					(r < 95) ? CMD_QUERY : CMD_SPARE;
			else
				op.cmd = (r < 35) ? CMD_INSERT : (r < 75) ? CMD_DELETE :
					(r < 90) ? CMD_QUERY : CMD_SPARE;
			op.value = pick_value();
			send_item(op, 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire

@@ sim.f @@
design/mtlq_pkg.sv
design/mtlq_ram.sv
design/min_tracking_linear_queue.sv
sim/tb.sv
